// ----- design/clne_pkg.sv -----
// shared types, codes and the power-up step table of the lcd nibble encoder
// no dependencies
`default_nettype none

package clne_pkg;

  // command codes of the input channel (code 3 means nothing)
  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_PUT  = 2'd1,
    CMD_GOTO = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROW_COUNT    = 2'd0,
    CFG_COLUMN_COUNT = 2'd1,
    CFG_BACKLIGHT_ON = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgDataWidth = 6;

  // result kinds
  typedef enum logic {
    RES_WRITE = 1'b0,
    RES_WAIT  = 1'b1
  } kind_e;

  // operations handed from front to back
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_BYTE  = 2'd2
  } op_e;

  // special characters of the put command
  localparam logic [7:0] ChFormFeed = 8'h0C;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChBackspace = 8'h08;

  // command bytes
  localparam logic [7:0] ByteCursorLeft = 8'h10;
  localparam logic       SetDdramBit    = 1'b1;

  // ddram base address of each row
  localparam logic [6:0] RowBase [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  // power-up table layout: the clear is its tail
  localparam int unsigned StepWidth  = 5;
  localparam logic [StepWidth-1:0] ClearFirst = 5'd21;
  localparam logic [StepWidth-1:0] InitLast   = 5'd23;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [2:0] row_count;
    logic [5:0] column_count;
    logic       backlight_on;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic       rs;
    logic [7:0] data;
  } qent_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] nibble;
    logic [5:0] pause_ms;
  } tstep_t;

  // power-up sequence followed by clear, one result per step
  function automatic tstep_t init_step(logic [StepWidth-1:0] step);
    tstep_t s;
    s = '{kind: RES_WRITE, nibble: 4'h0, pause_ms: 6'd0};
    case (step)
      5'd0:  s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd50};
      5'd1:  s.nibble = 4'h3;
      5'd2:  s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd3:  s.nibble = 4'h3;
      5'd4:  s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd5:  s.nibble = 4'h3;
      5'd6:  s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd7:  s.nibble = 4'h2;
      5'd8:  s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd9:  s.nibble = 4'h2;
      5'd10: s.nibble = 4'h8;
      5'd11: s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd12: s.nibble = 4'h0;
      5'd13: s.nibble = 4'hC;
      5'd14: s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd15: s.nibble = 4'h0;
      5'd16: s.nibble = 4'h1;
      5'd17: s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd18: s.nibble = 4'h0;
      5'd19: s.nibble = 4'h6;
      5'd20: s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd5};
      5'd21: s.nibble = 4'h0;
      5'd22: s.nibble = 4'h1;
      5'd23: s = '{kind: RES_WAIT,  nibble: 4'h0, pause_ms: 6'd2};
      default: s = '{kind: RES_WRITE, nibble: 4'h0, pause_ms: 6'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/clne_cmd_if.sv -----
// command channel: valid/ready plus the command fields
// no dependencies
`default_nettype none

interface clne_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] char_code;
  logic [7:0] target_column;
  logic [7:0] target_row;

  modport source (output valid, command, char_code, target_column, target_row, input ready);
  modport sink (input valid, command, char_code, target_column, target_row, output ready);
endinterface

`default_nettype wire

// ----- design/clne_res_if.sv -----
// result channel: valid/ready plus one bus action per beat
// no dependencies
`default_nettype none

interface clne_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       register_select;
  logic       backlight;
  logic [3:0] nibble;
  logic [5:0] pause_ms;
  logic       last;

  modport source (output valid, kind, register_select, backlight, nibble, pause_ms, last,
                  input ready);
  modport sink (input valid, kind, register_select, backlight, nibble, pause_ms, last,
                output ready);
endinterface

`default_nettype wire

// ----- design/clne_front.sv -----
// front end: accepts commands, clamps positions, tracks the row, builds queue entries
// depends on clne_pkg and clne_cmd_if
`default_nettype none

module clne_front
  import clne_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  clne_cmd_if.sink    cmd_i,
  input  wire         q_full_i,
  output logic        q_push_o,
  output qent_t       q_ent_o
);

  logic [1:0] row_q, row_d;
  logic [2:0] rows_eff;
  logic [1:0] row_lim;
  logic [5:0] cols_eff;
  logic [5:0] col_clamp;
  logic [1:0] goto_row;
  logic [2:0] next_row;
  logic [1:0] nl_row;
  logic [1:0] sel_row;
  logic [5:0] sel_col;
  logic [6:0] addr;
  logic       accept;

  assign cmd_i.ready = !q_full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // out-of-range counts act as the nearest legal value
  always_comb begin
    if (cfg_i.row_count == 3'd0) rows_eff = 3'd1;
    else if (cfg_i.row_count > 3'd4) rows_eff = 3'd4;
    else rows_eff = cfg_i.row_count;
    if (cfg_i.column_count == 6'd0) cols_eff = 6'd1;
    else if (cfg_i.column_count > 6'd40) cols_eff = 6'd40;
    else cols_eff = cfg_i.column_count;
  end

  assign row_lim   = 2'(rows_eff - 3'd1);
  assign goto_row  = (cmd_i.target_row >= {5'd0, rows_eff}) ? row_lim : cmd_i.target_row[1:0];
  assign next_row  = {1'b0, row_q} + 3'd1;
  assign nl_row    = (next_row >= rows_eff) ? row_lim : next_row[1:0];
  assign col_clamp = (cmd_i.target_column >= {2'd0, cols_eff}) ? 6'(cols_eff - 6'd1)
                                                                 : cmd_i.target_column[5:0];

  always_comb begin
    q_push_o = 1'b0;
    q_ent_o  = '{op: OP_BYTE, rs: 1'b0, data: 8'h00};
    row_d    = row_q;
    sel_row  = goto_row;
    sel_col  = col_clamp;
    case (cmd_i.command)
      CMD_INIT: begin
        q_push_o   = accept;
        q_ent_o.op = OP_INIT;
        row_d      = 2'd0;
      end
      CMD_PUT: begin
        q_push_o = accept;
        if (cmd_i.char_code == ChFormFeed) begin
          q_ent_o.op = OP_CLEAR;
          row_d      = 2'd0;
        end else if (cmd_i.char_code == ChNewline) begin
          sel_row = nl_row;
          sel_col = 6'd0;
          row_d   = nl_row;
          q_ent_o.data = {SetDdramBit, addr};
        end else if (cmd_i.char_code == ChBackspace) begin
          q_ent_o.data = ByteCursorLeft;
        end else begin
          q_ent_o.rs   = 1'b1;
          q_ent_o.data = cmd_i.char_code;
        end
      end
      CMD_GOTO: begin
        q_push_o     = accept;
        row_d        = goto_row;
        q_ent_o.data = {SetDdramBit, addr};
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

  // base plus column stays below 128 for legal columns
  assign addr = RowBase[sel_row] + {1'b0, sel_col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 2'd0;
    end else if (accept) begin
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/clne_queue.sv -----
// short fifo of operations between front and back
// depends on clne_pkg
`default_nettype none

module clne_queue
  import clne_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    push_i,
  input  qent_t  ent_i,
  input  wire    pop_i,
  output qent_t  head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  qent_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/clne_back.sv -----
// back end: steps through each operation and drives the registered result channel
// depends on clne_pkg and clne_res_if
`default_nettype none

module clne_back
  import clne_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          backlight_i,
  input  qent_t        head_i,
  input  wire          q_empty_i,
  output logic         q_pop_o,
  clne_res_if.source   res_o
);

  logic                 busy_q;
  op_e                  op_q;
  logic                 rs_q;
  logic [7:0]           data_q;
  logic [StepWidth-1:0] step_q;

  logic       out_valid_q;
  kind_e      out_kind_q;
  logic       out_rs_q, out_bl_q, out_last_q;
  logic [3:0] out_nib_q;
  logic [5:0] out_ms_q;

  tstep_t tbl;
  kind_e  cur_kind;
  logic   cur_rs;
  logic [3:0] cur_nib;
  logic [5:0] cur_ms;
  logic   final_step;
  logic   emit;
  logic   load;

  assign tbl = init_step(step_q);

  always_comb begin
    if (op_q == OP_BYTE) begin
      cur_kind   = RES_WRITE;
      cur_rs     = rs_q;
      cur_nib    = step_q[0] ? data_q[3:0] : data_q[7:4];
      cur_ms     = 6'd0;
      final_step = step_q[0];
    end else begin
      cur_kind   = tbl.kind;
      cur_rs     = 1'b0;
      cur_nib    = tbl.nibble;
      cur_ms     = tbl.pause_ms;
      final_step = (step_q == InitLast);
    end
  end

  assign emit    = busy_q && (!out_valid_q || res_o.ready);
  assign load    = (!busy_q || (emit && final_step)) && !q_empty_i;
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= OP_BYTE;
      step_q      <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        op_q   <= head_i.op;
        step_q <= (head_i.op == OP_CLEAR) ? ClearFirst : '0;
      end else if (emit) begin
        busy_q <= !final_step;
        step_q <= step_q + StepWidth'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q   <= head_i.rs;
      data_q <= head_i.data;
    end
    if (emit) begin
      out_kind_q <= cur_kind;
      out_rs_q   <= cur_rs;
      out_bl_q   <= (cur_kind == RES_WRITE) ? backlight_i : 1'b0;
      out_nib_q  <= cur_nib;
      out_ms_q   <= cur_ms;
      out_last_q <= final_step;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.kind            = out_kind_q;
  assign res_o.register_select = out_rs_q;
  assign res_o.backlight       = out_bl_q;
  assign res_o.nibble          = out_nib_q;
  assign res_o.pause_ms        = out_ms_q;
  assign res_o.last            = out_last_q;

endmodule

`default_nettype wire

// ----- design/char_lcd_nibble_command_encoder.sv -----
// first beat of a command: via the queue, the back-end state and the output register
// one beat per cycle while the receiver is ready; a put is 2 beats, a goto 2, a clear 3,
//   an init 24, set by the back-end step counter that emits one bus action per cycle
// a two-entry operation queue lets commands be taken while the back end is busy
// reset: async active low; config returns to 4 rows, 20 columns, backlight off; row 0
`default_nettype none

module char_lcd_nibble_command_encoder
  import clne_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  // configuration write port
  input  wire                     cfg_we_i,
  input  wire  [1:0]              cfg_index_i,
  input  wire  [CfgDataWidth-1:0] cfg_data_i,
  // command beats in, bus action beats out
  clne_cmd_if.sink                cmd_i,
  clne_res_if.source              res_o
);

  cfg_t  cfg_q;
  qent_t q_ent, q_head;
  logic  q_push, q_pop, q_full, q_empty;

  // configuration registers: the user must write them only while idle; the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{row_count: 3'd4, column_count: 6'd20, backlight_on: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:    cfg_q.row_count    <= cfg_data_i[2:0];
        CFG_COLUMN_COUNT: cfg_q.column_count <= cfg_data_i[5:0];
        CFG_BACKLIGHT_ON: cfg_q.backlight_on <= cfg_data_i[0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // front: classify, clamp and track the cursor row
  clne_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_ent_o  (q_ent)
  );

  // queue between the two halves
  clne_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ent_i   (q_ent),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // back: sequence nibble writes and waits into the output register
  clne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .backlight_i (cfg_q.backlight_on),
    .head_i      (q_head),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ----- sim/char_lcd_nibble_command_encoder_tb.sv -----
// self-checking bench for the lcd nibble command encoder: random commands, settings and stalls
// predicts every bus action beat and checks it; needs clne_pkg, clne_cmd_if, clne_res_if, the rtl
`default_nettype none

module char_lcd_nibble_command_encoder_tb;
  import clne_pkg::*;

  // run shape
  localparam int unsigned CycleLimit      = 500000;
  localparam int unsigned SettleCycles    = 16;
  localparam int unsigned LongStallCycles = 400;
  localparam int unsigned RandomPhases    = 6;
  localparam int unsigned ItemsPerPhase   = 38;
  localparam int unsigned MaxReports      = 10;

  // command code that the block must ignore
  localparam logic [1:0] CmdUnused = 2'd3;

  // characters with a meaning of their own
  localparam logic [7:0] FormFeedChar  = 8'h0C;
  localparam logic [7:0] NewlineChar   = 8'h0A;
  localparam logic [7:0] BackspaceChar = 8'h08;

  // register select values
  localparam logic RegCommand = 1'b0;
  localparam logic RegData    = 1'b1;

  // bus bytes, nibbles and waits of the display protocol
  localparam logic [7:0] ClearByte      = 8'h01;
  localparam logic [7:0] CursorLeftByte = 8'h10;
  localparam logic [3:0] WakeNibble     = 4'h3;
  localparam logic [3:0] FourBitNibble  = 4'h2;
  localparam logic [7:0] SetupBytes [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};
  localparam logic [5:0] PowerUpWaitMs  = 6'd50;
  localparam logic [5:0] StepWaitMs     = 6'd5;
  localparam logic [5:0] ClearWaitMs    = 6'd2;
  localparam logic [6:0] DdramRowBase [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  typedef struct packed {
    kind_e      kind;
    logic       rs;
    logic       bl;
    logic [3:0] nibble;
    logic [5:0] pause_ms;
    logic       last;
  } lcd_action_t;

  // keeps the display settings and cursor row, queues the bus actions each command causes
  class lcd_action_scoreboard;
    lcd_action_t expected_q[$];
    logic [2:0]  row_count;
    logic [5:0]  column_count;
    logic        backlight_on;
    logic [1:0]  cursor_row;
    int unsigned mismatches;

    function new();
      row_count    = 3'd4;
      column_count = 6'd20;
      backlight_on = 1'b0;
      cursor_row   = 2'd0;
      mismatches   = 0;
    endfunction

    function void set_settings(logic [2:0] rows, logic [5:0] cols, logic light);
      row_count    = rows;
      column_count = cols;
      backlight_on = light;
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function void push_write(logic rs, logic [3:0] nib);
      expected_q.push_back('{kind: RES_WRITE, rs: rs, bl: backlight_on, nibble: nib,
                             pause_ms: 6'd0, last: 1'b0});
    endfunction

    // waits carry nothing but the length
    function void push_wait(logic [5:0] ms);
      expected_q.push_back('{kind: RES_WAIT, rs: 1'b0, bl: 1'b0, nibble: 4'h0,
                             pause_ms: ms, last: 1'b0});
    endfunction

    function void push_byte(logic rs, logic [7:0] b);
      push_write(rs, b[7:4]);
      push_write(rs, b[3:0]);
    endfunction

    function void push_clear();
      push_byte(RegCommand, ClearByte);
      push_wait(ClearWaitMs);
      cursor_row = 2'd0;
    endfunction

    // out-of-range sizes saturate to 1..4 rows and 1..40 columns
    function void push_goto(int unsigned col, int unsigned row);
      int unsigned rows;
      int unsigned cols;
      logic [6:0]  addr;
      rows = (row_count == 0) ? 1 : (row_count > 4) ? 4 : row_count;
      cols = (column_count == 0) ? 1 : (column_count > 40) ? 40 : column_count;
      if (row >= rows) row = rows - 1;
      if (col >= cols) col = cols - 1;
      cursor_row = row[1:0];
      addr = DdramRowBase[cursor_row] + col[6:0];
      push_byte(RegCommand, {1'b1, addr});
    endfunction

    function void note_command(logic [1:0] command, logic [7:0] ch, logic [7:0] col,
                               logic [7:0] row);
      int unsigned queued_earlier;
      queued_earlier = expected_q.size();
      case (command)
        CMD_INIT: begin
          push_wait(PowerUpWaitMs);
          repeat (3) begin
            push_write(RegCommand, WakeNibble);
            push_wait(StepWaitMs);
          end
          push_write(RegCommand, FourBitNibble);
          push_wait(StepWaitMs);
          for (int i = 0; i < 4; i++) begin
            push_byte(RegCommand, SetupBytes[i]);
            push_wait(StepWaitMs);
          end
          push_clear();
        end
        CMD_PUT: begin
          if (ch == FormFeedChar) push_clear();
          else if (ch == NewlineChar) push_goto(0, 32'(cursor_row) + 1);
          else if (ch == BackspaceChar) push_byte(RegCommand, CursorLeftByte);
          else push_byte(RegData, ch);
        end
        CMD_GOTO: push_goto(col, row);
        default: ;
      endcase
      if (expected_q.size() > queued_earlier) expected_q[expected_q.size() - 1].last = 1'b1;
    endfunction

    function string describe(lcd_action_t a);
      return $sformatf("kind=%0d rs=%0d bl=%0d nibble=%h pause_ms=%0d last=%0d",
                       a.kind, a.rs, a.bl, a.nibble, a.pause_ms, a.last);
    endfunction

    function void check_action(lcd_action_t seen);
      lcd_action_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("unexpected beat: %s", describe(seen));
        return;
      end
      want = expected_q.pop_front();
      if (seen.kind !== want.kind || seen.rs !== want.rs || seen.bl !== want.bl ||
          seen.nibble !== want.nibble || seen.pause_ms !== want.pause_ms ||
          seen.last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("beat mismatch: expected %s", describe(want));
          $display("               actual   %s", describe(seen));
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  clne_cmd_if cmd_if ();
  clne_res_if res_if ();

  lcd_action_scoreboard sb;

  // knobs shared by the sender, the receiver and the main sequence
  bit source_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  bit long_stall_req = 1'b0;

  int unsigned cycle_count = 0;

  char_lcd_nibble_command_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .cmd_i       (cmd_if),
    .res_o       (res_if)
  );

  always #5 clk_i = ~clk_i;

  // watchdog: a hung handshake or a lost beat ends here
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // every accepted result beat goes against the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    lcd_action_t seen;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.kind     = kind_e'(res_if.kind);
      seen.rs       = res_if.register_select;
      seen.bl       = res_if.backlight;
      seen.nibble   = res_if.nibble;
      seen.pause_ms = res_if.pause_ms;
      seen.last     = res_if.last;
      sb.check_action(seen);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req) begin
        // hold off long enough for the operation queue to fill and block the input
        long_stall_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LongStallCycles) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // offer one command beat, maybe after an idle burst; returns at the edge that took it
  // valid stays high afterwards so back-to-back beats need no second assignment
  task automatic send_command(logic [1:0] command, logic [7:0] ch, logic [7:0] col,
                              logic [7:0] row);
    int unsigned gap;
    gap = (source_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= command;
    cmd_if.char_code     <= ch;
    cmd_if.target_column <= col;
    cmd_if.target_row    <= row;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(command, ch, col, row);
  endtask

  // unused fields get random values so they can be seen to have no effect
  task automatic put_char(logic [7:0] ch);
    send_command(CMD_PUT, ch, 8'($urandom), 8'($urandom));
  endtask

  task automatic goto_pos(logic [7:0] col, logic [7:0] row);
    send_command(CMD_GOTO, 8'($urandom), col, row);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  ch;
    logic [7:0]  col;
    logic [7:0]  row;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom);
    col  = 8'($urandom);
    row  = 8'($urandom);
    if (pick < 4) begin
      send_command(CMD_INIT, ch, col, row);
    end else if (pick < 8) begin
      send_command(CmdUnused, ch, col, row);
    end else if (pick < 33) begin
      // mostly positions near the display edges, sometimes anything
      if ($urandom_range(0, 3) != 0) begin
        col = 8'($urandom_range(0, 44));
        row = 8'($urandom_range(0, 5));
      end
      send_command(CMD_GOTO, ch, col, row);
    end else begin
      case ($urandom_range(0, 9))
        0: ch = FormFeedChar;
        1: ch = NewlineChar;
        2: ch = BackspaceChar;
        default: ;
      endcase
      send_command(CMD_PUT, ch, col, row);
    end
  endtask

  // drop valid, wait for every predicted beat, then give ignored commands time to retire
  task automatic wait_until_idle();
    cmd_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one write per register on consecutive edges, only while the block is idle
  task automatic apply_settings(logic [2:0] rows, logic [5:0] cols, logic light);
    wait_until_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= {3'b000, rows};
    @(posedge clk_i);
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_data  <= cols;
    @(posedge clk_i);
    cfg_index <= CFG_BACKLIGHT_ON;
    cfg_data  <= {5'b00000, light};
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_settings(rows, cols, light);
  endtask

  initial begin : main_sequence
    logic [2:0] rows;
    logic [5:0] cols;

    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    cmd_if.valid         = 1'b0;
    cmd_if.command       = '0;
    cmd_if.char_code     = '0;
    cmd_if.target_column = '0;
    cmd_if.target_row    = '0;
    sb = new();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset settings: power-up, plain and boundary characters
    send_command(CMD_INIT, 8'($urandom), 8'($urandom), 8'($urandom));
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    // newline walks down and sticks at the last row
    repeat (4) put_char(NewlineChar);
    put_char(BackspaceChar);
    put_char(FormFeedChar);
    goto_pos(8'd19, 8'd3);
    goto_pos(8'hFF, 8'hFF);
    goto_pos(8'd0, 8'd0);
    // unused code must produce nothing
    send_command(CmdUnused, 8'($urandom), 8'($urandom), 8'($urandom));

    // sizes above range saturate, backlight on
    apply_settings(3'd7, 6'd63, 1'b1);
    goto_pos(8'hFF, 8'hFF);
    goto_pos(8'd39, 8'd2);
    put_char(NewlineChar);
    put_char(8'h80);

    // zero sizes act as one row and one column
    apply_settings(3'd0, 6'd0, 1'b0);
    goto_pos(8'hFF, 8'hFF);
    put_char(NewlineChar);
    put_char(8'h7F);

    // single row, widest legal display
    apply_settings(3'd1, 6'd40, 1'b1);
    goto_pos(8'd40, 8'd0);
    put_char(NewlineChar);
    put_char(FormFeedChar);

    // random part, new settings per phase
    for (int p = 0; p < RandomPhases; p++) begin
      rows = 3'($urandom_range(0, 7));
      cols = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(1, 40));
      apply_settings(rows, cols, 1'($urandom_range(0, 1)));
      // last phase runs with no idling on either side
      source_gaps_on = (p != RandomPhases - 1);
      sink_stalls_on = (p != RandomPhases - 1);
      if (p == 1) begin
        // receiver holds off while the sender keeps pushing beats
        long_stall_req = 1'b1;
        source_gaps_on = 1'b0;
      end
      repeat (ItemsPerPhase) send_random_item();
    end

    wait_until_idle();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
